// ===== hdl/elevation_grid_slope_unit_assert.svh =====
// Assertion macros shared by the slope unit RTL.
`ifndef ELEVATION_GRID_SLOPE_UNIT_ASSERT_SVH
`define ELEVATION_GRID_SLOPE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define EGS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("elevation slope assertion failed");
`define EGS_ASSERT_RST(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("elevation slope reset assertion failed");
`else
`define EGS_ASSERT(label, prop)
`define EGS_ASSERT_RST(label, prop)
`endif
`endif

// ===== hdl/egs_pkg.sv =====
package egs_pkg;
	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 1024;
	localparam int ELEV_BITS    = 24;
	localparam int CORDIC_STEPS = 16;

	localparam int ADDR_W   = $clog2(MAX_WIDTH);
	localparam int COORD_W  = 10;
	localparam int DIM_W    = 11;
	localparam int CELL_W   = 20;
	localparam int SLOPE_W  = 15;
	localparam int PADDR_W  = 4;
	localparam int SAMPLE_W = ELEV_BITS + 1;
	localparam int DIFF_W   = ELEV_BITS + 2;
	localparam int ABS_W    = ELEV_BITS + 1;
	localparam int SQ_W     = 2 * ABS_W;
	localparam int RAD_W    = 2 * ABS_W + 2;
	localparam int ROOT_STEPS = RAD_W / 2;
	localparam int CNT_W    = $clog2(ROOT_STEPS);
	localparam int NORM_W   = 40;
	localparam int NORM_TOP = 39;
	localparam int HALVE_SH = 30;
	localparam int CORD_W   = 43;
	localparam int ANG_W    = 25;
	localparam int STEP_W   = 5;

	localparam logic [SLOPE_W-1:0] SLOPE_MAX = 15'd23040;

	localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
	localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
	localparam logic [1:0] REG_CELL_SIZE  = 2'd2;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] nx;
		logic signed [DIFF_W-1:0] ny;
	} slope_req_t;

	typedef struct packed {
		logic                     valid;
		logic signed [CORD_W-1:0] x;
		logic signed [CORD_W-1:0] y;
		logic signed [ANG_W-1:0]  z;
	} cord_t;

	// atan(2^-i) in units of 2^-16 degree.
	function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STEP_W-1:0] step);
		logic signed [ANG_W-1:0] a;
		unique case (step)
			5'd0:  a = ANG_W'(2949120);
			5'd1:  a = ANG_W'(1740967);
			5'd2:  a = ANG_W'(919879);
			5'd3:  a = ANG_W'(466945);
			5'd4:  a = ANG_W'(234379);
			5'd5:  a = ANG_W'(117304);
			5'd6:  a = ANG_W'(58666);
			5'd7:  a = ANG_W'(29335);
			5'd8:  a = ANG_W'(14668);
			5'd9:  a = ANG_W'(7334);
			5'd10: a = ANG_W'(3667);
			5'd11: a = ANG_W'(1833);
			5'd12: a = ANG_W'(917);
			5'd13: a = ANG_W'(458);
			5'd14: a = ANG_W'(229);
			5'd15: a = ANG_W'(115);
			5'd16: a = ANG_W'(57);
			5'd17: a = ANG_W'(29);
			5'd18: a = ANG_W'(14);
			5'd19: a = ANG_W'(7);
			5'd20: a = ANG_W'(4);
			5'd21: a = ANG_W'(2);
			5'd22: a = ANG_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction
endpackage

// ===== hdl/egs_in_if.sv =====
interface egs_in_if;
	import egs_pkg::*;
	logic                        valid;
	logic                        ready;
	logic signed [ELEV_BITS-1:0] elevation;
	logic                        elevation_known;
	modport source(output valid, elevation, elevation_known, input ready);
	modport sink(input valid, elevation, elevation_known, output ready);
endinterface

// ===== hdl/egs_out_if.sv =====
interface egs_out_if;
	import egs_pkg::*;
	logic               valid;
	logic               ready;
	logic [SLOPE_W-1:0] slope_deg;
	logic               slope_known;
	logic [COORD_W-1:0] cell_x;
	logic [COORD_W-1:0] cell_y;
	logic               last;
	modport source(output valid, slope_deg, slope_known, cell_x, cell_y, last, input ready);
	modport sink(input valid, slope_deg, slope_known, cell_x, cell_y, last, output ready);
endinterface

// ===== hdl/elevation_grid_slope_unit.sv =====
// Elevation grid slope unit. Elevation samples enter in raster order on the samples channel,
// row 0 first, each with a known flag; slopes in degrees (unsigned Q7.8) leave on the results
// channel, tagged with their cell column and row, with last set on the final cell of the map.
// Results for row y come out while row y+1 streams in, and the final row is emitted alongside
// its own samples, so an item causes zero, one, two or three results. Map width, height and
// cell size are set over the APB port (byte addresses 0, 4 and 8); a write to any of them
// restarts the map at cell (0,0). Items are handled one at a time. An item is accepted,
// fetches its line-buffer neighbors (with an extra fetch at the start of a row), works
// through its result slots, closes them and retires. Each result that needs a slope runs
// through the shared slope unit: a flat cell finishes after the square root, others pass
// the square-root recurrence, single-bit normalizing shifts and a 16-cell CORDIC chain.
// Results with unknown inputs skip the slope unit, and a map narrower or shorter than two
// cells skips the neighbor fetch. A result waits in the output register until the sink
// takes it, and the next slot does not start before then. The two line buffers are
// 1024-entry single-read memories used in ping-pong, swapped at each row end, and need no
// clearing after reset.
`include "elevation_grid_slope_unit_assert.svh"
module elevation_grid_slope_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	egs_in_if.sink                       samples,
	egs_out_if.source                    results,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [egs_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import egs_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_JOB   = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;
	localparam logic [2:0] ST_ADV   = 3'd5;

	// Result slots of one item: the cell above (the item's own cell in a map narrower or
	// shorter than two cells), the last-row cell to the left, and the final cell of the map.
	localparam logic [1:0] JOB_MAIN  = 2'd0;
	localparam logic [1:0] JOB_LEFT  = 2'd1;
	localparam logic [1:0] JOB_FINAL = 2'd2;
	localparam logic [1:0] JOB_END   = 2'd3;

	// Configuration registers.
	logic [DIM_W-1:0]  width_q, height_q, w_eff, h_eff, wm1, hm1;
	logic [CELL_W-1:0] cell_q;
	logic              cfg_wr;

	// Item control.
	logic [2:0]         state_q;
	logic [COORD_W-1:0] col_q, row_q, x_q, y_q, xi, yi;
	logic               bank_q, tiny_q, first_q;
	logic [ADDR_W-1:0]  ra_q;
	logic [1:0]         job_q;
	sample_t            s_q, s_in;

	// Neighbor window over the row above, and the recent samples of the current row.
	sample_t win_prev_q, win_cur_q, win_next_q, two_q, rs0_q, rs1_q;

	// Line buffers.
	sample_t           mem0 [MAX_WIDTH];
	sample_t           mem1 [MAX_WIDTH];
	sample_t           rd0_q, rd1_q, above_rd, two_rd;
	logic [ADDR_W-1:0] addr0, addr1;
	logic              we0, we1;

	// Result assembly.
	sample_t            c, ha, hb, va, vb;
	logic               hone, vone, all_known, need, x_last, y_last, job_load, out_load;
	logic [COORD_W-1:0] jx, jy, jx_q, jy_q;
	logic               jlast, jlast_q;
	logic signed [DIFF_W-1:0] dh, dv;
	slope_req_t         req;
	logic               slp_start, slp_idle, slp_done;
	logic [SLOPE_W-1:0] slp_slope;

	// Output register.
	logic               out_valid_q, out_known_q, out_last_q;
	logic [SLOPE_W-1:0] out_slope_q;
	logic [COORD_W-1:0] out_x_q, out_y_q;

	// Width and height in use are clamped to one through the maximum.
	assign w_eff = (width_q == '0) ? DIM_W'(1) :
		((width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q);
	assign h_eff = (height_q == '0) ? DIM_W'(1) :
		((height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q);
	assign wm1 = w_eff - DIM_W'(1);
	assign hm1 = h_eff - DIM_W'(1);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[PADDR_W-1:2])
			REG_MAP_WIDTH:  prdata = 32'(width_q);
			REG_MAP_HEIGHT: prdata = 32'(height_q);
			REG_CELL_SIZE:  prdata = 32'(cell_q);
			default:        prdata = '0;
		endcase
	end

	assign samples.ready = (state_q == ST_IDLE);

	// A position past the map in use (after the map shrank) restarts at the origin.
	always_comb begin
		if (({1'b0, col_q} >= w_eff) || ({1'b0, row_q} >= h_eff)) begin
			xi = '0;
			yi = '0;
		end else begin
			xi = col_q;
			yi = row_q;
		end
	end
	assign s_in = samples.elevation_known ? {1'b1, samples.elevation} : '0;

	// Bank select names which memory holds the row above; the other holds the row two above
	// and receives the current row, so a row end swaps them by flipping the select.
	assign addr0    = bank_q ? x_q[ADDR_W-1:0] : ra_q;
	assign addr1    = bank_q ? ra_q : x_q[ADDR_W-1:0];
	assign above_rd = bank_q ? rd1_q : rd0_q;
	assign two_rd   = bank_q ? rd0_q : rd1_q;
	assign we0      = (state_q == ST_ADV) && !tiny_q && bank_q;
	assign we1      = (state_q == ST_ADV) && !tiny_q && !bank_q;

	always_ff @(posedge clk) begin
		rd0_q <= mem0[addr0];
		if (we0) mem0[x_q[ADDR_W-1:0]] <= s_q;
	end

	always_ff @(posedge clk) begin
		rd1_q <= mem1[addr1];
		if (we1) mem1[x_q[ADDR_W-1:0]] <= s_q;
	end

	assign x_last = ({1'b0, x_q} == wm1);
	assign y_last = ({1'b0, y_q} == hm1);

	// Neighbor selection for the result slot being worked on. One-sided differences
	// are doubled so every gradient shares the denominator of twice the cell size.
	always_comb begin
		c     = s_q;
		ha    = s_q;
		hb    = s_q;
		va    = s_q;
		vb    = s_q;
		hone  = 1'b1;
		vone  = 1'b1;
		jx    = x_q;
		jy    = y_q;
		jlast = 1'b0;
		need  = 1'b0;
		unique case (job_q)
			JOB_MAIN: begin
				need = tiny_q || (y_q != '0);
				c    = win_cur_q;
				if (x_q == '0) begin
					ha = win_cur_q;
					hb = win_next_q;
				end else if (x_last) begin
					ha = win_prev_q;
					hb = win_cur_q;
				end else begin
					ha   = win_prev_q;
					hb   = win_next_q;
					hone = 1'b0;
				end
				if (y_q == COORD_W'(1)) begin
					va = win_cur_q;
				end else begin
					va   = two_q;
					vone = 1'b0;
				end
				vb = s_q;
				jy = y_q - COORD_W'(1);
				if (tiny_q) begin
					jy    = y_q;
					jlast = x_last && y_last;
				end
			end
			JOB_LEFT: begin
				need = !tiny_q && y_last && (x_q != '0);
				c    = rs0_q;
				hb   = s_q;
				va   = win_prev_q;
				vb   = rs0_q;
				if (x_q == COORD_W'(1)) begin
					ha = rs0_q;
					jx = '0;
				end else begin
					ha   = rs1_q;
					hone = 1'b0;
					jx   = x_q - COORD_W'(1);
				end
			end
			JOB_FINAL: begin
				need  = !tiny_q && y_last && x_last;
				ha    = rs0_q;
				va    = win_cur_q;
				jlast = 1'b1;
			end
			JOB_END: need = 1'b0;
			default: need = 1'b0;
		endcase
	end

	assign all_known = c[ELEV_BITS] & ha[ELEV_BITS] & hb[ELEV_BITS] & va[ELEV_BITS] &
		vb[ELEV_BITS];
	assign dh = DIFF_W'($signed(hb[ELEV_BITS-1:0])) - DIFF_W'($signed(ha[ELEV_BITS-1:0]));
	assign dv = DIFF_W'($signed(vb[ELEV_BITS-1:0])) - DIFF_W'($signed(va[ELEV_BITS-1:0]));
	assign req.nx = hone ? (dh <<< 1) : dh;
	assign req.ny = vone ? (dv <<< 1) : dv;

	// A result slot starts only with the output register empty, so nothing else can
	// be waiting in it when the slot finishes.
	assign job_load  = (state_q == ST_JOB) && (job_q != JOB_END) && need && !out_valid_q &&
		(tiny_q || !all_known);
	assign slp_start = (state_q == ST_JOB) && (job_q != JOB_END) && need && !out_valid_q &&
		!tiny_q && all_known;
	assign out_load  = job_load || ((state_q == ST_WAIT) && slp_done);

	egs_slope u_slope (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (slp_start),
		.req      (req),
		.cell_size(cell_q),
		.idle     (slp_idle),
		.done     (slp_done),
		.slope    (slp_slope)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			width_q  <= DIM_W'(1024);
			height_q <= DIM_W'(1024);
			cell_q   <= CELL_W'(1024);
			col_q    <= '0;
			row_q    <= '0;
			bank_q   <= 1'b0;
			job_q    <= JOB_MAIN;
			first_q  <= 1'b0;
			tiny_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						tiny_q  <= (w_eff < DIM_W'(2)) || (h_eff < DIM_W'(2));
						first_q <= (xi == '0);
						job_q   <= JOB_MAIN;
						if ((w_eff < DIM_W'(2)) || (h_eff < DIM_W'(2))) begin
							state_q <= ST_JOB;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: state_q <= ST_SHIFT;
				ST_SHIFT: begin
					if (first_q) begin
						first_q <= 1'b0;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_JOB;
					end
				end
				ST_JOB: begin
					if (job_q == JOB_END) begin
						state_q <= ST_ADV;
					end else if (!need || job_load) begin
						job_q <= job_q + 2'd1;
					end else if (slp_start) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (slp_done) begin
						job_q   <= job_q + 2'd1;
						state_q <= ST_JOB;
					end
				end
				ST_ADV: begin
					state_q <= ST_IDLE;
					if (({1'b0, x_q} + DIM_W'(1)) >= w_eff) begin
						col_q <= '0;
						if (!tiny_q) bank_q <= !bank_q;
						if (({1'b0, y_q} + DIM_W'(1)) >= h_eff) begin
							row_q <= '0;
						end else begin
							row_q <= y_q + COORD_W'(1);
						end
					end else begin
						col_q <= x_q + COORD_W'(1);
						row_q <= y_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// Configuration must arrive only while idle (the block does not enforce it), so it may override the position.
			if (cfg_wr) begin
				unique case (paddr[PADDR_W-1:2])
					REG_MAP_WIDTH: begin
						width_q <= pwdata[DIM_W-1:0];
						col_q   <= '0;
						row_q   <= '0;
					end
					REG_MAP_HEIGHT: begin
						height_q <= pwdata[DIM_W-1:0];
						col_q    <= '0;
						row_q    <= '0;
					end
					REG_CELL_SIZE: begin
						cell_q <= pwdata[CELL_W-1:0];
						col_q  <= '0;
						row_q  <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// Item payload, neighbor window and recent samples.
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			s_q  <= s_in;
			x_q  <= xi;
			y_q  <= yi;
			ra_q <= (xi == '0) ? '0 : ADDR_W'(xi + COORD_W'(1));
		end
		if (state_q == ST_SHIFT) begin
			win_prev_q <= win_cur_q;
			win_cur_q  <= win_next_q;
			win_next_q <= above_rd;
			two_q      <= two_rd;
			if (first_q) ra_q <= ADDR_W'(1);
		end
		if (slp_start) begin
			jx_q    <= jx;
			jy_q    <= jy;
			jlast_q <= jlast;
		end
		if ((state_q == ST_ADV) && !tiny_q) begin
			rs1_q <= rs0_q;
			rs0_q <= s_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			out_slope_q <= '0;
			out_known_q <= 1'b0;
			out_x_q     <= jx;
			out_y_q     <= jy;
			out_last_q  <= jlast;
		end else if (out_load) begin
			out_slope_q <= slp_slope;
			out_known_q <= 1'b1;
			out_x_q     <= jx_q;
			out_y_q     <= jy_q;
			out_last_q  <= jlast_q;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.slope_deg   = out_slope_q;
	assign results.slope_known = out_known_q;
	assign results.cell_x      = out_x_q;
	assign results.cell_y      = out_y_q;
	assign results.last        = out_last_q;

	`EGS_ASSERT(a_one_item_at_a_time, (samples.valid && samples.ready) |=> !samples.ready)
	`EGS_ASSERT(a_slope_start_idle, slp_start |-> slp_idle)
	`EGS_ASSERT(a_load_into_empty, out_load |-> !out_valid_q)
	`EGS_ASSERT(a_last_on_last_row, (results.valid && results.last) |-> (results.cell_y == hm1[COORD_W-1:0]))
	`EGS_ASSERT_RST(a_reset_quiet, !arst_n |-> !results.valid)
endmodule

// ===== hdl/egs_cordic_cell.sv =====
module egs_cordic_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [egs_pkg::STEP_W-1:0]   step,
	input  egs_pkg::cord_t               a,
	output egs_pkg::cord_t               b
);
	import egs_pkg::*;

	logic                     valid_q;
	logic signed [CORD_W-1:0] x_q, y_q, x_n, y_n, xs, ys;
	logic signed [ANG_W-1:0]  z_q, z_n, ang;

	// One vectoring micro-rotation: drive y toward zero.
	always_comb begin
		xs  = a.x >>> step;
		ys  = a.y >>> step;
		ang = atan_q16(step);
		if (a.y > 0) begin
			x_n = a.x + ys;
			y_n = a.y - xs;
			z_n = a.z + ang;
		end else begin
			x_n = a.x - ys;
			y_n = a.y + xs;
			z_n = a.z - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= a.valid;
		end
	end

	always_ff @(posedge clk) begin
		x_q <= x_n;
		y_q <= y_n;
		z_q <= z_n;
	end

	assign b = '{valid: valid_q, x: x_q, y: y_q, z: z_q};
endmodule

// ===== hdl/egs_slope.sv =====
`include "elevation_grid_slope_unit_assert.svh"
module egs_slope (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  egs_pkg::slope_req_t          req,
	input  logic [egs_pkg::CELL_W-1:0]   cell_size,
	output logic                         idle,
	output logic                         done,
	output logic [egs_pkg::SLOPE_W-1:0]  slope
);
	import egs_pkg::*;

	localparam logic [2:0] SL_IDLE  = 3'd0;
	localparam logic [2:0] SL_HALVE = 3'd1;
	localparam logic [2:0] SL_SQ    = 3'd2;
	localparam logic [2:0] SL_SUM   = 3'd3;
	localparam logic [2:0] SL_ROOT  = 3'd4;
	localparam logic [2:0] SL_NORM  = 3'd5;
	localparam logic [2:0] SL_CORD  = 3'd6;
	localparam logic [2:0] SL_DONE  = 3'd7;

	logic [2:0]         state_q;
	logic [ABS_W-1:0]   ax_q, ay_q, ax_n, ay_n;
	logic [NORM_W-1:0]  d_q, m_q;
	logic [CELL_W-1:0]  cs_eff;
	logic [SQ_W-1:0]    sqx_q, sqy_q;
	logic [RAD_W-1:0]   v_q, r_q, bit_q, trial, r_n;
	logic [CNT_W-1:0]   cnt_q;
	logic [SLOPE_W-1:0] slope_q, slope_n;
	logic               norm_go;
	logic [ANG_W-1:0]   zr;
	cord_t              link [CORDIC_STEPS+1];

	assign ax_n   = req.nx[DIFF_W-1] ? ABS_W'(-req.nx) : ABS_W'(req.nx);
	assign ay_n   = req.ny[DIFF_W-1] ? ABS_W'(-req.ny) : ABS_W'(req.ny);
	assign cs_eff = (cell_size == '0) ? CELL_W'(1) : cell_size;

	// Restoring square root, one result bit per cycle.
	assign trial = r_q + bit_q;
	assign r_n   = (v_q >= trial) ? ((r_q >> 1) + bit_q) : (r_q >> 1);

	assign norm_go = (state_q == SL_NORM) && (m_q != '0) && (((m_q | d_q) >> NORM_TOP) != '0);
	assign link[0] = '{valid: norm_go, x: $signed(CORD_W'(d_q)), y: $signed(CORD_W'(m_q)),
		z: '0};

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		egs_cordic_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.step  (STEP_W'(i)),
			.a     (link[i]),
			.b     (link[i+1])
		);
	end

	always_comb begin
		zr = ANG_W'(link[CORDIC_STEPS].z + ANG_W'(128)) >> 8;
		if (link[CORDIC_STEPS].z <= 0) begin
			slope_n = '0;
		end else if (zr > ANG_W'(SLOPE_MAX)) begin
			slope_n = SLOPE_MAX;
		end else begin
			slope_n = zr[SLOPE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SL_IDLE;
		end else begin
			unique case (state_q)
				SL_IDLE:  if (start) state_q <= SL_HALVE;
				SL_HALVE: if (((ax_q | ay_q) >> HALVE_SH) == '0) state_q <= SL_SQ;
				SL_SQ:    state_q <= SL_SUM;
				SL_SUM:   state_q <= SL_ROOT;
				SL_ROOT:  if (cnt_q == CNT_W'(ROOT_STEPS - 1)) state_q <= SL_NORM;
				SL_NORM: begin
					if (m_q == '0) begin
						state_q <= SL_DONE;
					end else if (norm_go) begin
						state_q <= SL_CORD;
					end
				end
				SL_CORD:  if (link[CORDIC_STEPS].valid) state_q <= SL_DONE;
				SL_DONE:  state_q <= SL_IDLE;
				default:  state_q <= SL_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			SL_IDLE: begin
				ax_q <= ax_n;
				ay_q <= ay_n;
				d_q  <= NORM_W'({cs_eff, 1'b0});
			end
			SL_HALVE: begin
				if (((ax_q | ay_q) >> HALVE_SH) != '0) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
					d_q  <= d_q >> 1;
				end
			end
			SL_SQ: begin
				sqx_q <= SQ_W'(ax_q) * SQ_W'(ax_q);
				sqy_q <= SQ_W'(ay_q) * SQ_W'(ay_q);
			end
			SL_SUM: begin
				v_q   <= RAD_W'(sqx_q) + RAD_W'(sqy_q);
				r_q   <= '0;
				bit_q <= RAD_W'(1) << (RAD_W - 2);
				cnt_q <= '0;
			end
			SL_ROOT: begin
				if (v_q >= trial) v_q <= v_q - trial;
				r_q   <= r_n;
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + CNT_W'(1);
				m_q   <= NORM_W'(r_n);
			end
			SL_NORM: begin
				if (m_q == '0) begin
					slope_q <= '0;
				end else if (!norm_go) begin
					m_q <= m_q << 1;
					d_q <= d_q << 1;
				end
			end
			SL_CORD: if (link[CORDIC_STEPS].valid) slope_q <= slope_n;
			SL_DONE: ;
			default: ;
		endcase
	end

	assign idle  = (state_q == SL_IDLE);
	assign done  = (state_q == SL_DONE);
	assign slope = slope_q;

	`EGS_ASSERT(a_done_pulse, done |=> !done)
	`EGS_ASSERT(a_start_when_idle, start |-> (state_q == SL_IDLE))
	`EGS_ASSERT(a_chain_out_in_cord, link[CORDIC_STEPS].valid |-> (state_q == SL_CORD))
endmodule
